@@ rtl/aled_pkg.sv @@
// Shared types and constants for the addressable LED bit encoder.
// No dependencies; imported by every module of the block.
package aled_pkg;

    localparam int TICK_W  = 20;   // segment duration width
    localparam int DUR_W   = 16;   // bit timing register width
    localparam int COLOR_W = 24;   // one GRB word
    localparam int BYTE_W  = 8;
    localparam int SEG_W   = 6;    // holds a segment index up to 48

    localparam logic [SEG_W-1:0] SEG_FIRST_BIT = 6'd1;
    localparam logic [SEG_W-1:0] SEG_LAST      = 6'd48;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes (byte address bits [4:2])
    localparam logic [2:0] REG_RESET_LOW = 3'd0;
    localparam logic [2:0] REG_ZERO_HIGH = 3'd1;
    localparam logic [2:0] REG_ZERO_LOW  = 3'd2;
    localparam logic [2:0] REG_ONE_HIGH  = 3'd3;
    localparam logic [2:0] REG_ONE_LOW   = 3'd4;

    localparam logic [TICK_W-1:0] RESET_LOW_INIT = 20'd800000;
    localparam logic [DUR_W-1:0]  ZERO_HIGH_INIT = 16'd300;
    localparam logic [DUR_W-1:0]  ZERO_LOW_INIT  = 16'd900;
    localparam logic [DUR_W-1:0]  ONE_HIGH_INIT  = 16'd600;
    localparam logic [DUR_W-1:0]  ONE_LOW_INIT   = 16'd600;

    typedef struct packed {
        logic [TICK_W-1:0] reset_low;
        logic [DUR_W-1:0]  zero_high;
        logic [DUR_W-1:0]  zero_low;
        logic [DUR_W-1:0]  one_high;
        logic [DUR_W-1:0]  one_low;
    } t_timing;

    // Queue handshake between front and back
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    typedef enum logic {
        BACK_IDLE,
        BACK_RUN
    } t_back_state;

endpackage

@@ rtl/aled_front.sv @@
// Front end: accepts a color request and packs it into a GRB send word.
// Depends on aled_pkg; feeds aled_queue.
module aled_front
    import aled_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [BYTE_W-1:0]  i_red_level,
    input  logic [BYTE_W-1:0]  i_green_level,
    input  logic [BYTE_W-1:0]  i_blue_level,
    input  t_queue_status      i_queue,
    output logic               o_push,
    output logic [COLOR_W-1:0] o_word
);

    logic               r_valid;
    logic               n_valid;
    logic [COLOR_W-1:0] r_word;
    logic               accept;

    // Hold a request only while the queue cannot take it
    assign o_in_stall = r_valid & i_queue.full;
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_push     = r_valid & ~i_queue.full;
    assign o_word     = r_word;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Order the bytes as sent: green, red, blue, MSB first
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= {i_green_level, i_red_level, i_blue_level};
        end
    end

endmodule

@@ rtl/aled_queue.sv @@
// Short FIFO of packed GRB words between front and back.
// Depends on aled_pkg.
module aled_queue
    import aled_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [COLOR_W-1:0] i_data,
    input  logic               i_pop,
    output logic [COLOR_W-1:0] o_data,
    output t_queue_status      o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [COLOR_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_FULL);
    assign o_data         = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !(i_push && !i_pop))
        else $error("queue push while full");

    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_pop)
        else $error("queue pop while empty");

endmodule

@@ rtl/aled_back.sv @@
// Back end: sequences one GRB word into 49 line segments, one per cycle while the output is not stalled.
// Depends on aled_pkg; reads from aled_queue and the timing registers.
module aled_back
    import aled_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_timing            i_timing,
    input  t_queue_status      i_queue,
    input  logic [COLOR_W-1:0] i_word,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_line_level,
    output logic [TICK_W-1:0]  o_segment_ticks,
    output logic               o_final_segment
);

    t_back_state        r_state;
    t_back_state        n_state;
    logic [SEG_W-1:0]   r_seg;
    logic [SEG_W-1:0]   n_seg;
    logic [COLOR_W-1:0] r_word;
    logic [COLOR_W-1:0] n_word;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               r_level;
    logic               n_level;
    logic [TICK_W-1:0]  r_ticks;
    logic [TICK_W-1:0]  n_ticks;
    logic               r_final;
    logic               n_final;
    logic               advance;
    logic               bit_one;

    assign advance = ~r_out_valid | ~i_out_stall;
    assign bit_one = r_word[COLOR_W-1];

    assign o_out_valid     = r_out_valid;
    assign o_line_level    = r_level;
    assign o_segment_ticks = r_ticks;
    assign o_final_segment = r_final;

    always_comb begin
        n_state     = r_state;
        n_seg       = r_seg;
        n_word      = r_word;
        n_out_valid = r_out_valid;
        n_level     = r_level;
        n_ticks     = r_ticks;
        n_final     = r_final;
        o_pop       = 1'b0;
        case (r_state)
            BACK_IDLE: begin
                if (advance) begin
                    n_out_valid = ~i_queue.empty;
                    if (!i_queue.empty) begin
                        // start a frame with the low reset segment
                        o_pop   = 1'b1;
                        n_word  = i_word;
                        n_level = 1'b0;
                        n_ticks = i_timing.reset_low;
                        n_final = 1'b0;
                        n_seg   = SEG_FIRST_BIT;
                        n_state = BACK_RUN;
                    end
                end
            end
            BACK_RUN: begin
                if (advance) begin
                    n_out_valid = 1'b1;
                    n_seg       = r_seg + 1'b1;
                    if (r_seg[0]) begin
                        n_level = 1'b1;
                        n_final = 1'b0;
                        n_ticks = TICK_W'(bit_one ? i_timing.one_high : i_timing.zero_high);
                    end else begin
                        n_level = 1'b0;
                        n_final = (r_seg == SEG_LAST);
                        n_ticks = TICK_W'(bit_one ? i_timing.one_low : i_timing.zero_low);
                        n_word  = {r_word[COLOR_W-2:0], 1'b0};
                    end
                    if (r_seg == SEG_LAST) begin
                        n_state = BACK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BACK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg   <= n_seg;
        r_word  <= n_word;
        r_level <= n_level;
        r_ticks <= n_ticks;
        r_final <= n_final;
    end

    a_run_has_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BACK_RUN |-> r_out_valid)
        else $error("sequencer running with empty output register");

    a_final_is_low : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_final |-> !r_level)
        else $error("final segment must be low");

    a_final_ends_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_final |-> r_state == BACK_IDLE)
        else $error("final segment while frame still running");

endmodule

@@ rtl/addressable_led_bit_encoder_top.sv @@
// Top level of the addressable LED bit encoder: timing registers and APB port.
// Depends on aled_pkg, aled_front, aled_queue and aled_back.
//
// Each accepted color request (red, green, blue bytes) becomes one frame of
// 49 line segments on the output channel: a low reset segment, then 24 bits
// sent green, red, blue, MSB first, each bit a high segment followed by a
// low segment whose durations come from the one-bit or zero-bit timing
// registers. The last low segment carries o_final_segment. One segment
// leaves per cycle while the output is not stalled, and frames follow each
// other with no gap; the back end sequencer, which emits one segment per
// cycle, sets this rate. The front end takes the next request at once and
// parks it in a QUEUE_DEPTH-entry queue, so up to QUEUE_DEPTH + 1 requests
// can wait behind the frame on the line. Registers sit at byte addresses 0
// (reset low ticks, 20 bits), 4 (zero high), 8 (zero low), 12 (one high)
// and 16 (one low); wider write data is cut to the register width. Write
// them only while the block is idle.
module addressable_led_bit_encoder_top
    import aled_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_red_level,
    input  logic [BYTE_W-1:0] i_green_level,
    input  logic [BYTE_W-1:0] i_blue_level,
    // segment channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_line_level,
    output logic [TICK_W-1:0] o_segment_ticks,
    output logic              o_final_segment,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_timing            r_timing;
    t_queue_status      queue_status;
    logic [2:0]         reg_index;
    logic               cfg_write;
    logic               push;
    logic               pop;
    logic [COLOR_W-1:0] front_word;
    logic [COLOR_W-1:0] queue_word;

    // Decode the APB access; the port never inserts wait states
    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_W-1:2];
    assign cfg_write = psel & penable & pwrite;

    // Timing registers: keep only the low bits of the write data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.reset_low <= RESET_LOW_INIT;
            r_timing.zero_high <= ZERO_HIGH_INIT;
            r_timing.zero_low  <= ZERO_LOW_INIT;
            r_timing.one_high  <= ONE_HIGH_INIT;
            r_timing.one_low   <= ONE_LOW_INIT;
        end else if (cfg_write) begin
            case (reg_index)
                REG_RESET_LOW: r_timing.reset_low <= pwdata[TICK_W-1:0];
                REG_ZERO_HIGH: r_timing.zero_high <= pwdata[DUR_W-1:0];
                REG_ZERO_LOW:  r_timing.zero_low  <= pwdata[DUR_W-1:0];
                REG_ONE_HIGH:  r_timing.one_high  <= pwdata[DUR_W-1:0];
                REG_ONE_LOW:   r_timing.one_low   <= pwdata[DUR_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // Read back the addressed register, zero elsewhere
    always_comb begin
        case (reg_index)
            REG_RESET_LOW: prdata = DATA_W'(r_timing.reset_low);
            REG_ZERO_HIGH: prdata = DATA_W'(r_timing.zero_high);
            REG_ZERO_LOW:  prdata = DATA_W'(r_timing.zero_low);
            REG_ONE_HIGH:  prdata = DATA_W'(r_timing.one_high);
            REG_ONE_LOW:   prdata = DATA_W'(r_timing.one_low);
            default:       prdata = '0;
        endcase
    end

    // Front end: take the request and pack the send word
    aled_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_red_level   (i_red_level),
        .i_green_level (i_green_level),
        .i_blue_level  (i_blue_level),
        .i_queue       (queue_status),
        .o_push        (push),
        .o_word        (front_word)
    );

    // Queue: decouple request intake from segment output
    aled_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (front_word),
        .i_pop    (pop),
        .o_data   (queue_word),
        .o_status (queue_status)
    );

    // Back end: emit the frame one segment per cycle while the output is not stalled
    aled_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_timing        (r_timing),
        .i_queue         (queue_status),
        .i_word          (queue_word),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_line_level    (o_line_level),
        .o_segment_ticks (o_segment_ticks),
        .o_final_segment (o_final_segment)
    );

endmodule
